// ----- hw/rtl/bta_pkg.sv -----
// Package for the binary to ASCII number converter.
// Holds the transaction types, the sequencer states, ASCII constants and the digit helper.
// No dependencies.
package bta_pkg;

   // widths of the datapath
   localparam int unsigned VALUE_W    = 32;
   localparam int unsigned BCD_DIGITS = 10;
   localparam int unsigned BCD_W      = 4 * BCD_DIGITS;
   localparam int unsigned CHAR_W     = 7;

   // ASCII codes
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_UPPER = 7'h41;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

   // conversion modes
   localparam logic MODE_DEC = 1'b0;
   localparam logic MODE_HEX = 1'b1;

   typedef struct packed {
      logic               mode;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_LOCATE,
      ST_SIGN,
      ST_DIGITS
   } state_type;

   // one digit (0..15) to its ASCII code, uppercase letters above nine
   function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
      logic [CHAR_W-1:0] ext;
      ext = {3'b000, d};
      if (d < 4'd10) begin
         digit_char = CHAR_ZERO + ext;
      end else begin
         digit_char = CHAR_UPPER + ext - 7'd10;
      end
   endfunction

endpackage

// ----- hw/rtl/binary_to_ascii_number_converter_unit.sv -----
// Top level of the binary to ASCII number converter.
// Sequencer, digit buffer and character output; uses bta_pkg and bta_dabble_step.
//
//   channel  ports                       direction  transfer
//   request  start, busy, req_payload    in         start && !busy
//   response rsp_strobe, rsp_payload     out        rsp_strobe, one char per cycle
//
// Decimal: load, 32 shift-add-3 iterations of the shared BCD step, locate the leading
// digit, then one character per cycle (up to 11).
// Hex: load, locate, then up to 8 characters.
// busy is high from the accepting edge until the final character is registered.
// Reset is synchronous and clears the sequencer and the response strobe.
// The receiver cannot stall; each character is on the ports for exactly one cycle.
module binary_to_ascii_number_converter_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bta_pkg::req_type req_payload,
   output logic             rsp_strobe,
   output bta_pkg::rsp_type rsp_payload
);

   bta_pkg::state_type state_ff, state_in;
   logic [4:0]                    count_ff, count_in;
   logic [bta_pkg::VALUE_W-1:0]   shift_ff, shift_in;
   logic [bta_pkg::BCD_W-1:0]     bcd_ff, bcd_in;
   logic [3:0]                    ptr_ff, ptr_in;
   logic                          neg_ff, neg_in;
   logic                          rsp_strobe_ff, rsp_strobe_in;
   bta_pkg::rsp_type              rsp_ff, rsp_in;

   logic [bta_pkg::BCD_W-1:0]     bcd_step;
   logic [3:0]                    lead_idx;
   logic                          accept;

   assign accept = start && (state_ff == bta_pkg::ST_IDLE);

   // shared conversion step
   bta_dabble_step u_step (
      .bcd_cur  (bcd_ff),
      .bit_in   (shift_ff[bta_pkg::VALUE_W-1]),
      .bcd_next (bcd_step)
   );

   // highest nonzero digit, zero when the number is zero
   always_comb begin
      lead_idx = 4'd0;
      for (int i = 0; i < bta_pkg::BCD_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] != 4'd0) begin
            lead_idx = i[3:0];
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bta_pkg::ST_IDLE: begin
            if (start) begin
               if (req_payload.mode == bta_pkg::MODE_HEX) begin
                  state_in = bta_pkg::ST_LOCATE;
               end else begin
                  state_in = bta_pkg::ST_CONVERT;
               end
            end
         end
         bta_pkg::ST_CONVERT: begin
            if (count_ff == 5'd0) begin
               state_in = bta_pkg::ST_LOCATE;
            end
         end
         bta_pkg::ST_LOCATE: begin
            if (neg_ff) begin
               state_in = bta_pkg::ST_SIGN;
            end else begin
               state_in = bta_pkg::ST_DIGITS;
            end
         end
         bta_pkg::ST_SIGN: begin
            state_in = bta_pkg::ST_DIGITS;
         end
         bta_pkg::ST_DIGITS: begin
            if (ptr_ff == 4'd0) begin
               state_in = bta_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bta_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in      = count_ff;
      shift_in      = shift_ff;
      bcd_in        = bcd_ff;
      ptr_in        = ptr_ff;
      neg_in        = neg_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      case (state_ff)
         bta_pkg::ST_IDLE: begin
            if (start) begin
               count_in = 5'd31;
               if (req_payload.mode == bta_pkg::MODE_HEX) begin
                  // hex digits are the nibbles themselves
                  neg_in   = 1'b0;
                  shift_in = req_payload.value;
                  bcd_in   = {{(bta_pkg::BCD_W - bta_pkg::VALUE_W){1'b0}},
                              req_payload.value};
               end else begin
                  neg_in   = req_payload.value[bta_pkg::VALUE_W-1];
                  bcd_in   = '0;
                  if (req_payload.value[bta_pkg::VALUE_W-1]) begin
                     shift_in = ~req_payload.value + 32'd1;
                  end else begin
                     shift_in = req_payload.value;
                  end
               end
            end
         end
         bta_pkg::ST_CONVERT: begin
            bcd_in   = bcd_step;
            shift_in = {shift_ff[bta_pkg::VALUE_W-2:0], 1'b0};
            count_in = count_ff - 5'd1;
         end
         bta_pkg::ST_LOCATE: begin
            ptr_in = lead_idx;
         end
         bta_pkg::ST_SIGN: begin
            rsp_strobe_in    = 1'b1;
            rsp_in.character = bta_pkg::CHAR_MINUS;
            rsp_in.last      = 1'b0;
         end
         bta_pkg::ST_DIGITS: begin
            rsp_strobe_in    = 1'b1;
            rsp_in.character = bta_pkg::digit_char(bcd_ff[{ptr_ff, 2'b00} +: 4]);
            rsp_in.last      = (ptr_ff == 4'd0);
            ptr_in           = ptr_ff - 4'd1;
         end
         default: begin
            rsp_strobe_in = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bta_pkg::ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      count_ff <= count_in;
      shift_ff <= shift_in;
      bcd_ff   <= bcd_in;
      ptr_ff   <= ptr_in;
      neg_ff   <= neg_in;
      rsp_ff   <= rsp_in;
   end

   assign busy        = (state_ff != bta_pkg::ST_IDLE);
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   // an accepted transaction makes the unit busy on the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("unit not busy after accepting a transaction");

   // characters only come out of the sign and digit states
   a_strobe_src: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(state_ff) == bta_pkg::ST_SIGN ||
                      $past(state_ff) == bta_pkg::ST_DIGITS))
      else $error("response strobe without an emitting state");

   // the final character is followed by a quiet cycle
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.last) |=> !rsp_strobe)
      else $error("character emitted right after the final one");

   // the sign is never the final character
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.character == bta_pkg::CHAR_MINUS) |-> !rsp_payload.last)
      else $error("minus sign flagged as final character");

endmodule

// ----- hw/rtl/bta_dabble_step.sv -----
// One shift-and-add-3 step of the binary to BCD conversion.
// Adjusts every BCD digit of five or more by three, then shifts in one binary bit.
// Depends on bta_pkg.
module bta_dabble_step (
   input  logic [bta_pkg::BCD_W-1:0] bcd_cur,
   input  logic                      bit_in,
   output logic [bta_pkg::BCD_W-1:0] bcd_next
);

   logic [bta_pkg::BCD_W-1:0] adjusted;

   // digit correction, all digits in parallel
   always_comb begin
      for (int i = 0; i < bta_pkg::BCD_DIGITS; i++) begin
         if (bcd_cur[4*i +: 4] >= 4'd5) begin
            adjusted[4*i +: 4] = bcd_cur[4*i +: 4] + 4'd3;
         end else begin
            adjusted[4*i +: 4] = bcd_cur[4*i +: 4];
         end
      end
   end

   // shift the next binary bit into the bottom digit
   assign bcd_next = {adjusted[bta_pkg::BCD_W-2:0], bit_in};

endmodule

// ----- dv/tb_binary_to_ascii_number_converter_unit.sv -----
`timescale 1ns / 1ps
// Testbench for binary_to_ascii_number_converter_unit: directed and random conversions through
// a queue-fed driver, with a strobe monitor checked against a character predictor.
// Depends on bta_pkg and the converter RTL.
module tb_binary_to_ascii_number_converter_unit;

   localparam int unsigned STALL_LIMIT  = 2000;
   localparam int unsigned DRAIN_CYCLES = 60;
   localparam int unsigned RANDOM_ITEMS = 280;
   localparam int unsigned IDLE_PCT     = 38;
   localparam int unsigned MAX_IDLE_RUN = 50;
   // transactions in this window go out back to back
   localparam int unsigned CALM_FIRST   = 120;
   localparam int unsigned CALM_LAST    = 190;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             start       = 1'b0;
   logic             busy;
   bta_pkg::req_type req_payload = '0;
   logic             rsp_strobe;
   bta_pkg::rsp_type rsp_payload;

   bta_pkg::req_type pending_items[$];
   bta_pkg::rsp_type expected_chars[$];
   bta_pkg::rsp_type next_char;
   logic        req_taken    = 1'b0;
   int unsigned idle_left    = 0;
   int unsigned items_sent   = 0;
   int unsigned items_taken  = 0;
   int unsigned hex_taken    = 0;
   int unsigned neg_taken    = 0;
   int unsigned chars_seen   = 0;
   int unsigned error_count  = 0;
   int unsigned stall_cycles = 0;

   binary_to_ascii_number_converter_unit dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Character predictor: sign, then digits most significant first, last flag on the final one
   function automatic void predict_chars(input bta_pkg::req_type item);
      logic [bta_pkg::VALUE_W-1:0] magnitude;
      logic [bta_pkg::VALUE_W-1:0] digit;
      int unsigned                 radix;
      logic [bta_pkg::CHAR_W-1:0]  digits_lsd[$];
      bta_pkg::rsp_type            ch;
      magnitude = item.value;
      radix     = 10;
      if (item.mode == bta_pkg::MODE_HEX) begin
         radix = 16;
      end else if (item.value[bta_pkg::VALUE_W-1]) begin
         // two's complement magnitude; the most negative word maps onto itself
         magnitude    = ~item.value + 1'b1;
         ch.character = bta_pkg::CHAR_MINUS;
         ch.last      = 1'b0;
         expected_chars.push_back(ch);
      end
      do begin
         digit = magnitude % radix;
         digits_lsd.push_back((digit < 10)
            ? bta_pkg::CHAR_ZERO + digit[bta_pkg::CHAR_W-1:0]
            : bta_pkg::CHAR_UPPER + digit[bta_pkg::CHAR_W-1:0] - 7'd10);
         magnitude = magnitude / radix;
      end while (magnitude != 0);
      for (int i = digits_lsd.size() - 1; i >= 0; i--) begin
         ch.character = digits_lsd[i];
         ch.last      = (i == 0);
         expected_chars.push_back(ch);
      end
   endfunction

   task automatic queue_item(input logic mode, input logic [bta_pkg::VALUE_W-1:0] value);
      bta_pkg::req_type item;
      item.mode  = mode;
      item.value = value;
      pending_items.push_back(item);
   endtask

   // Driver: holds a transaction until taken, otherwise idles for random stretches
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         if (idle_left != 0) begin
            idle_left <= idle_left - 1;
            start     <= 1'b0;
         end else if (pending_items.size() == 0) begin
            start <= 1'b0;
         end else if (!(items_sent >= CALM_FIRST && items_sent < CALM_LAST) &&
                      $urandom_range(99) < IDLE_PCT) begin
            idle_left <= $urandom_range(MAX_IDLE_RUN - 1);
            start     <= 1'b0;
         end else begin
            req_payload <= pending_items.pop_front();
            start       <= 1'b1;
            items_sent  <= items_sent + 1;
         end
      end
   end

   // Monitor: predicts on each accepted request, checks each strobed character
   always @(posedge clock) begin
      req_taken <= !reset && start && !busy;
      if (reset) begin
         stall_cycles <= 0;
      end else begin
         if (start && !busy) begin
            predict_chars(req_payload);
            items_taken++;
            if (req_payload.mode == bta_pkg::MODE_HEX) hex_taken++;
            else if (req_payload.value[bta_pkg::VALUE_W-1]) neg_taken++;
         end
         if (rsp_strobe) begin
            chars_seen++;
            if (expected_chars.size() == 0) begin
               $error("unexpected character %h with last %b",
                      rsp_payload.character, rsp_payload.last);
               error_count++;
            end else begin
               next_char = expected_chars.pop_front();
               if (rsp_payload.character !== next_char.character) begin
                  $error("character: expected %h, got %h",
                         next_char.character, rsp_payload.character);
                  error_count++;
               end
               if (rsp_payload.last !== next_char.last) begin
                  $error("last: expected %b, got %b", next_char.last, rsp_payload.last);
                  error_count++;
               end
            end
         end
         stall_cycles <= ((start && !busy) || rsp_strobe) ? 0 : stall_cycles + 1;
      end
   end

   // Watchdog on cycles with no transaction on either side
   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("FAIL");
      $finish;
   end

   // Stimulus, reset and end of run
   initial begin
      bta_pkg::req_type item;
      int unsigned      decade;
      // directed: zero, small and boundary values in both modes
      queue_item(bta_pkg::MODE_DEC, 32'd0);
      queue_item(bta_pkg::MODE_DEC, 32'd1);
      queue_item(bta_pkg::MODE_DEC, 32'd9);
      queue_item(bta_pkg::MODE_DEC, 32'd10);
      queue_item(bta_pkg::MODE_DEC, 32'd999999999);
      queue_item(bta_pkg::MODE_DEC, 32'd1000000000);
      queue_item(bta_pkg::MODE_DEC, 32'd123456789);
      queue_item(bta_pkg::MODE_DEC, 32'h7FFFFFFF);
      queue_item(bta_pkg::MODE_DEC, 32'h80000000);   // most negative value
      queue_item(bta_pkg::MODE_DEC, 32'h80000001);
      queue_item(bta_pkg::MODE_DEC, 32'hFFFFFFFF);   // minus one
      queue_item(bta_pkg::MODE_DEC, 32'hFFFFFFF6);   // minus ten
      queue_item(bta_pkg::MODE_HEX, 32'h0);
      queue_item(bta_pkg::MODE_HEX, 32'h1);
      queue_item(bta_pkg::MODE_HEX, 32'hA);
      queue_item(bta_pkg::MODE_HEX, 32'hF);
      queue_item(bta_pkg::MODE_HEX, 32'h10);
      queue_item(bta_pkg::MODE_HEX, 32'h12345678);
      queue_item(bta_pkg::MODE_HEX, 32'hABCDEF01);
      queue_item(bta_pkg::MODE_HEX, 32'h80000000);
      queue_item(bta_pkg::MODE_HEX, 32'hFFFFFFFF);
      // random: full words, narrow magnitudes, small negatives, decade edges
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         item.mode = 1'($urandom_range(1));
         case ($urandom_range(4))
            0, 1: item.value = $urandom();
            2: item.value = $urandom() >> $urandom_range(31);
            3: item.value = 32'd0 - $urandom_range(1000);
            default: begin
               decade = 1;
               repeat ($urandom_range(9)) decade = decade * 10;
               item.value = decade - 1 + $urandom_range(2);
            end
         endcase
         pending_items.push_back(item);
      end

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || start || expected_chars.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Converted %0d numbers (%0d hex, %0d negative decimal) into %0d characters.",
               items_taken, hex_taken, neg_taken, chars_seen);
      $display("Mismatches found: %0d", error_count);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
